// ===== hdl/blstk_pkg.sv =====
// shared types and constants of the bounded lifo stack
package blstk_pkg;

  localparam int WORD_W = 32;

  typedef enum logic [1:0] {
    OP_PUSH    = 2'd0,
    OP_POP     = 2'd1,
    OP_PEEK    = 2'd2,
    OP_DISPLAY = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic    push_wr;    // write push word at top, count up
    logic    cnt_dec;    // count down (pop)
    logic    rd_top;     // read top entry, cursor to top
    logic    rd_next;    // read entry below cursor, cursor down
    logic    ld_now;     // load a result without data
    status_t ld_status;  // status of that result
    logic    ld_mem;     // load a result from read data
    logic    ld_last;    // last mark of that result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
    logic full;
    logic cur_zero;
    logic out_free;
  } stat_t;

endpackage

// ===== hdl/blstk_ifs.sv =====
// valid/ready channel interfaces for stack requests and results
interface blstk_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          opcode;
  logic signed [blstk_pkg::WORD_W-1:0] push_value;

  modport source (output valid, output opcode, output push_value, input ready);
  modport sink   (input valid, input opcode, input push_value, output ready);
endinterface

interface blstk_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [blstk_pkg::WORD_W-1:0] data_word;
  logic                                data_valid;
  logic [1:0]                          status;
  logic                                is_empty;
  logic                                is_full;
  logic                                last;

  modport source (output valid, output data_word, output data_valid, output status,
                  output is_empty, output is_full, output last, input ready);
  modport sink   (input valid, input data_word, input data_valid, input status,
                  input is_empty, input is_full, input last, output ready);
endinterface

// ===== hdl/bounded_lifo_stack.sv =====
// top level of the bounded lifo stack of signed 32-bit words
// A last-in first-out stack with room for DEPTH signed words. Every request
// transaction on in_ch carries an opcode: push, pop, peek or display. Push,
// and any request that fails (push when full, pop/peek/display when empty),
// yields one result transaction loaded in the cycle of acceptance. Pop and
// peek go through the registered read port of the entry memory. Display
// walks the stack from top to bottom, one memory read per entry, and gives
// one result per entry, each further read waiting until the result register
// is free; the bottom entry carries last. Every result reports is_empty and
// is_full as they stand after the request. A new request is taken only when
// the controller is idle and the result register is free or being drained
// in that cycle. The entry memory needs no clearing: only written entries
// are ever read.
module bounded_lifo_stack #(
  parameter int DEPTH = 8
) (
  input  logic      clk,
  input  logic      rst,
  blstk_in_if.sink    in_ch,
  blstk_out_if.source out_ch
);
  import blstk_pkg::*;

  cmd_t  cmd;   // controller commands for the datapath
  stat_t st;    // datapath status back to the controller

  // controller: one-hot state machine that sequences each request
  blstk_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .opcode   (in_ch.opcode),
    .st       (st),
    .in_ready (in_ch.ready),
    .cmd      (cmd)
  );

  // datapath: entry memory, entry count, display cursor, result register
  blstk_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .push_value (in_ch.push_value),
    .st         (st),
    .out_ch     (out_ch)
  );

endmodule

// ===== hdl/blstk_ctrl.sv =====
// stack controller: sequences each request transaction
module blstk_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [1:0]       opcode,
  input  blstk_pkg::stat_t st,
  output logic             in_ready,
  output blstk_pkg::cmd_t  cmd
);
  import blstk_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE      = 4'b0001,
    S_READ_TOP  = 4'b0010,
    S_READ_DISP = 4'b0100,
    S_WAIT_DISP = 4'b1000
  } state_t;

  state_t  state, state_next;
  opcode_t op;
  logic    accept;

  assign op       = opcode_t'(opcode);
  assign in_ready = (state == S_IDLE) && st.out_free;
  assign accept   = in_ready && in_valid;

  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.ld_status = ST_OK;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (op)
            OP_PUSH: begin
              cmd.ld_now = 1'b1;
              if (st.full) begin
                cmd.ld_status = ST_OVERFLOW;
              end else begin
                cmd.push_wr = 1'b1;
              end
            end
            OP_POP: begin
              if (st.empty) begin
                cmd.ld_now    = 1'b1;
                cmd.ld_status = ST_UNDERFLOW;
              end else begin
                cmd.rd_top  = 1'b1;
                cmd.cnt_dec = 1'b1;
                state_next  = S_READ_TOP;
              end
            end
            OP_PEEK: begin
              if (st.empty) begin
                cmd.ld_now    = 1'b1;
                cmd.ld_status = ST_EMPTY;
              end else begin
                cmd.rd_top = 1'b1;
                state_next = S_READ_TOP;
              end
            end
            OP_DISPLAY: begin
              if (st.empty) begin
                cmd.ld_now    = 1'b1;
                cmd.ld_status = ST_EMPTY;
              end else begin
                cmd.rd_top = 1'b1;
                state_next = S_READ_DISP;
              end
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_READ_TOP: begin
        cmd.ld_mem  = 1'b1;
        cmd.ld_last = 1'b1;
        state_next  = S_IDLE;
      end
      S_READ_DISP: begin
        cmd.ld_mem  = 1'b1;
        cmd.ld_last = st.cur_zero;
        state_next  = st.cur_zero ? S_IDLE : S_WAIT_DISP;
      end
      S_WAIT_DISP: begin
        if (st.out_free) begin
          cmd.rd_next = 1'b1;
          state_next  = S_READ_DISP;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== hdl/blstk_dpath.sv =====
// stack datapath: entry memory, count, cursor and result register
module blstk_dpath #(
  parameter int DEPTH = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  blstk_pkg::cmd_t                     cmd,
  input  logic signed [blstk_pkg::WORD_W-1:0] push_value,
  output blstk_pkg::stat_t                    st,
  blstk_out_if.source                         out_ch
);
  import blstk_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [CW-1:0]            count, count_next;
  logic [AW-1:0]            cursor, top_addr, rd_addr;
  logic signed [WORD_W-1:0] mem [DEPTH];
  logic signed [WORD_W-1:0] rdata;

  logic                     out_valid;
  logic signed [WORD_W-1:0] data_word;
  logic                     data_valid;
  status_t                  status;
  logic                     is_empty, is_full, last;

  assign top_addr = AW'(count - CW'(1));
  assign rd_addr  = cmd.rd_top ? top_addr : (cursor - AW'(1));

  always_comb begin
    priority if (cmd.push_wr) begin
      count_next = count + CW'(1);
    end else if (cmd.cnt_dec) begin
      count_next = count - CW'(1);
    end else begin
      count_next = count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_top) begin
      cursor <= top_addr;
    end else if (cmd.rd_next) begin
      cursor <= cursor - AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push_wr) begin
      mem[count[AW-1:0]] <= push_value;
    end
    if (cmd.rd_top || cmd.rd_next) begin
      rdata <= mem[rd_addr];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.ld_now || cmd.ld_mem) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_now || cmd.ld_mem) begin
      is_empty <= (count_next == '0);
      is_full  <= (count_next == CW'(DEPTH));
    end
    if (cmd.ld_now) begin
      data_word  <= '0;
      data_valid <= 1'b0;
      status     <= cmd.ld_status;
      last       <= 1'b1;
    end else if (cmd.ld_mem) begin
      data_word  <= rdata;
      data_valid <= 1'b1;
      status     <= ST_OK;
      last       <= cmd.ld_last;
    end
  end

  assign st.empty    = (count == '0);
  assign st.full     = (count == CW'(DEPTH));
  assign st.cur_zero = (cursor == '0);
  assign st.out_free = !out_valid || out_ch.ready;

  assign out_ch.valid      = out_valid;
  assign out_ch.data_word  = data_word;
  assign out_ch.data_valid = data_valid;
  assign out_ch.status     = status;
  assign out_ch.is_empty   = is_empty;
  assign out_ch.is_full    = is_full;
  assign out_ch.last       = last;

endmodule

// ===== hdl/blstk_checker.sv =====
// port-level assertions for the bounded lifo stack and their bind
module blstk_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [blstk_pkg::WORD_W-1:0] data_word,
  input logic                                data_valid,
  input logic [1:0]                          status,
  input logic                                is_empty,
  input logic                                is_full,
  input logic                                last
);
  import blstk_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(data_word) && $stable(status)
      && $stable(last))
    else $error("result changed while stalled");

  // a result with a stack entry is always ok
  a_data_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && data_valid |-> status == ST_OK)
    else $error("data result with error status");

  // no entry means a zero word
  a_zero_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && !data_valid |-> data_word == '0)
    else $error("nonzero word without data");

  // an error result is always the only one of its request
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> last)
    else $error("error result not marked last");

  // stack cannot be empty and full at once
  a_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(is_empty && is_full))
    else $error("empty and full together");

endmodule

bind bounded_lifo_stack blstk_checker u_blstk_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .data_word  (out_ch.data_word),
  .data_valid (out_ch.data_valid),
  .status     (out_ch.status),
  .is_empty   (out_ch.is_empty),
  .is_full    (out_ch.is_full),
  .last       (out_ch.last)
);

// ===== test/tb_bounded_lifo_stack.sv =====
// self-checking testbench of the bounded lifo stack: directed table, then random traffic
module tb_bounded_lifo_stack;
  import blstk_pkg::*;

  localparam int DEPTH          = 8;
  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 8;
  localparam int RANDOM_ITEMS   = 335;
  // the last stretch of random items runs with no idling on either side
  localparam int QUIET_ITEMS    = 60;
  // receiver hold-off long enough to back the stall up into the request side
  localparam int LONG_HOLD      = 60;
  // a display can trail its request by the read and wait states of every entry
  localparam int TAIL_CYCLES    = 4 * DEPTH + 8;
  // longest run of cycles with no transaction on either channel
  localparam int WATCHDOG_LIMIT = 400;

  // one result transaction as the receiver sees it
  typedef struct packed {
    logic [WORD_W-1:0] data_word;
    logic              data_valid;
    status_t           status;
    logic              is_empty;
    logic              is_full;
    logic              last;
  } result_t;

  // one row of the directed table; result is typed in only where plain
  typedef struct packed {
    opcode_t           op;
    logic [WORD_W-1:0] value;
    logic              typed;
    result_t           want;
  } row_t;

  localparam int DIRECTED_COUNT = 25;

  localparam row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    // everything on an empty stack right after reset
    '{OP_POP,     32'h0000_0000, 1'b1, '{32'h0, 1'b0, ST_UNDERFLOW, 1'b1, 1'b0, 1'b1}},
    '{OP_PEEK,    32'h0000_0000, 1'b1, '{32'h0, 1'b0, ST_EMPTY,     1'b1, 1'b0, 1'b1}},
    '{OP_DISPLAY, 32'h0000_0000, 1'b1, '{32'h0, 1'b0, ST_EMPTY,     1'b1, 1'b0, 1'b1}},
    // word extremes in and out
    '{OP_PUSH,    32'h7FFF_FFFF, 1'b1, '{32'h0, 1'b0, ST_OK,        1'b0, 1'b0, 1'b1}},
    '{OP_PEEK,    32'h0000_0000, 1'b1, '{32'h7FFF_FFFF, 1'b1, ST_OK, 1'b0, 1'b0, 1'b1}},
    '{OP_PUSH,    32'h8000_0000, 1'b1, '{32'h0, 1'b0, ST_OK,        1'b0, 1'b0, 1'b1}},
    '{OP_POP,     32'h0000_0000, 1'b1, '{32'h8000_0000, 1'b1, ST_OK, 1'b0, 1'b0, 1'b1}},
    // fill to the brim
    '{OP_PUSH,    32'h0000_0000, 1'b0, '0},
    '{OP_PUSH,    32'hFFFF_FFFF, 1'b0, '0},
    '{OP_PUSH,    32'h0000_0001, 1'b0, '0},
    '{OP_PUSH,    32'h5555_5555, 1'b0, '0},
    '{OP_PUSH,    32'hAAAA_AAAA, 1'b0, '0},
    '{OP_PUSH,    32'h1234_5678, 1'b0, '0},
    '{OP_PUSH,    32'h8000_0000, 1'b1, '{32'h0, 1'b0, ST_OK,        1'b0, 1'b1, 1'b1}},
    // push on a full stack
    '{OP_PUSH,    32'h0000_0005, 1'b1, '{32'h0, 1'b0, ST_OVERFLOW,  1'b0, 1'b1, 1'b1}},
    // full display run, top to bottom
    '{OP_DISPLAY, 32'h0000_0000, 1'b0, '0},
    '{OP_PEEK,    32'h0000_0000, 1'b1, '{32'h8000_0000, 1'b1, ST_OK, 1'b0, 1'b1, 1'b1}},
    // drain back to empty
    '{OP_POP,     32'h0000_0000, 1'b0, '0},
    '{OP_POP,     32'h0000_0000, 1'b0, '0},
    '{OP_POP,     32'h0000_0000, 1'b0, '0},
    '{OP_POP,     32'h0000_0000, 1'b0, '0},
    '{OP_POP,     32'h0000_0000, 1'b0, '0},
    '{OP_POP,     32'h0000_0000, 1'b0, '0},
    '{OP_POP,     32'h0000_0000, 1'b0, '0},
    '{OP_POP,     32'h0000_0000, 1'b1, '{32'h7FFF_FFFF, 1'b1, ST_OK, 1'b1, 1'b0, 1'b1}}
  };

  logic clk = 1'b0;
  logic rst;

  blstk_in_if  req_if ();
  blstk_out_if res_if ();

  bounded_lifo_stack #(
    .DEPTH (DEPTH)
  ) u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (req_if),
    .out_ch (res_if)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // shadow copy of the stack contents
  logic [WORD_W-1:0] model_words [DEPTH];
  int                model_level;

  // results owed by the block, oldest first
  result_t due_results [$];

  int   mismatch_count;
  int   idle_cycles;
  logic hold_pending;
  logic quiet_tail;

  // apply one accepted request to the shadow stack and queue what it owes
  function automatic void apply_stack_op(input opcode_t op, input logic [WORD_W-1:0] value);
    result_t r;
    int      i;
    r = '0;
    r.last = 1'b1;
    case (op)
      OP_PUSH: begin
        if (model_level >= DEPTH) begin
          r.status = ST_OVERFLOW;
        end else begin
          model_words[model_level] = value;
          model_level++;
          r.status = ST_OK;
        end
      end
      OP_POP: begin
        if (model_level == 0) begin
          r.status = ST_UNDERFLOW;
        end else begin
          model_level--;
          r.data_word  = model_words[model_level];
          r.data_valid = 1'b1;
          r.status     = ST_OK;
        end
      end
      OP_PEEK: begin
        if (model_level == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.data_word  = model_words[model_level - 1];
          r.data_valid = 1'b1;
          r.status     = ST_OK;
        end
      end
      default: begin
        if (model_level == 0) begin
          r.status = ST_EMPTY;
        end else begin
          // all but the bottom entry go out here, the bottom one below
          for (i = model_level - 1; i > 0; i--) begin
            r.data_word  = model_words[i];
            r.data_valid = 1'b1;
            r.status     = ST_OK;
            r.is_empty   = 1'b0;
            r.is_full    = (model_level == DEPTH);
            r.last       = 1'b0;
            due_results.push_back(r);
          end
          r.data_word  = model_words[0];
          r.data_valid = 1'b1;
          r.status     = ST_OK;
          r.last       = 1'b1;
        end
      end
    endcase
    r.is_empty = (model_level == 0);
    r.is_full  = (model_level == DEPTH);
    due_results.push_back(r);
  endfunction

  function automatic void check_field(input string what, input logic [WORD_W-1:0] want,
                                      input logic [WORD_W-1:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
    end
  endfunction

  // offer one request transaction and wait for it to be taken
  task automatic offer_request(input opcode_t op, input logic [WORD_W-1:0] value,
                               input logic typed, input result_t want);
    @(negedge clk);
    req_if.valid      <= 1'b1;
    req_if.opcode     <= op;
    req_if.push_value <= value;
    do @(posedge clk); while (!req_if.ready);
    apply_stack_op(op, value);
    // a typed row stands in for the single result it causes
    if (typed) begin
      void'(due_results.pop_back());
      due_results.push_back(want);
    end
  endtask

  // sender gap of a given number of cycles
  task automatic rest_sender(input int cycles);
    @(negedge clk);
    req_if.valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // hold back requests until every owed result has come out
  task automatic wait_drained();
    @(negedge clk);
    req_if.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
  endtask

  // request side: reset, directed table, then random traffic
  initial begin : request_side
    int                n;
    int                push_pct;
    int                pick;
    opcode_t           op;
    logic [WORD_W-1:0] value;
    rst               = 1'b1;
    req_if.valid      = 1'b0;
    req_if.opcode     = OP_PUSH;
    req_if.push_value = '0;
    mismatch_count    = 0;
    model_level       = 0;
    hold_pending      = 1'b0;
    quiet_tail        = 1'b0;
    push_pct          = 50;
    for (n = 0; n < DEPTH; n++) model_words[n] = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    for (n = 0; n < DIRECTED_COUNT; n++) begin
      if ($urandom_range(4) == 0) rest_sender($urandom_range(1, 7));
      offer_request(DIRECTED_ROWS[n].op, DIRECTED_ROWS[n].value,
                    DIRECTED_ROWS[n].typed, DIRECTED_ROWS[n].want);
    end

    // sender pause until the directed results are all in
    wait_drained();

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      // push bias moves in blocks so the stack swings between empty and full
      if (n % 40 == 0) begin
        case ($urandom_range(2))
          0:       push_pct = 25;
          1:       push_pct = 50;
          default: push_pct = 80;
        endcase
      end
      if (n == 120) wait_drained();
      // receiver goes quiet for a long stretch while requests keep coming
      if (n == 180) hold_pending = 1'b1;
      if (n == RANDOM_ITEMS - QUIET_ITEMS) quiet_tail = 1'b1;

      pick = $urandom_range(99);
      if (pick < push_pct) begin
        op = OP_PUSH;
      end else begin
        pick = $urandom_range(9);
        if (pick < 5)      op = OP_POP;
        else if (pick < 8) op = OP_PEEK;
        else               op = OP_DISPLAY;
      end
      case ($urandom_range(7))
        0:       value = 32'h8000_0000;
        1:       value = 32'h7FFF_FFFF;
        2:       value = 32'h0000_0000;
        3:       value = 32'hFFFF_FFFF;
        default: value = $urandom;
      endcase

      if (!quiet_tail && $urandom_range(5) == 0) rest_sender($urandom_range(1, 7));
      offer_request(op, value, 1'b0, '0);
    end

    // let the last results out, then wait TAIL_CYCLES more for stray ones
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_bounded_lifo_stack passed");
    end else begin
      $display("tb_bounded_lifo_stack failed");
    end
    $finish;
  end

  // result side backpressure: random bursts, one long hold, none at the tail
  initial begin : result_side
    int gap;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_pending) begin
        res_if.ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
        hold_pending = 1'b0;
      end else if (!quiet_tail && $urandom_range(7) == 0) begin
        res_if.ready <= 1'b0;
        gap = $urandom_range(1, 7);
        repeat (gap - 1) @(negedge clk);
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // compare every result transaction with the oldest owed result
  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      if (due_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: result with none expected, expected nothing, actual word %h status %h",
                 $time, res_if.data_word, res_if.status);
      end else begin
        want = due_results.pop_front();
        check_field("data_word",  want.data_word,  res_if.data_word);
        check_field("data_valid", WORD_W'(want.data_valid), WORD_W'(res_if.data_valid));
        check_field("status",     WORD_W'(want.status),     WORD_W'(res_if.status));
        check_field("is_empty",   WORD_W'(want.is_empty),   WORD_W'(res_if.is_empty));
        check_field("is_full",    WORD_W'(want.is_full),    WORD_W'(res_if.is_full));
        check_field("last",       WORD_W'(want.last),       WORD_W'(res_if.last));
      end
    end
  end

  // watchdog: too long with no transaction on either channel
  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (!rst && idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_bounded_lifo_stack failed");
      $finish;
    end
  end

endmodule

// ===== bounded_lifo_stack.f =====
hdl/blstk_pkg.sv
hdl/blstk_ifs.sv
hdl/blstk_ctrl.sv
hdl/blstk_dpath.sv
hdl/bounded_lifo_stack.sv
hdl/blstk_checker.sv
test/tb_bounded_lifo_stack.sv
